>>> hdl/etc1_pkg.sv
// ----------------------------------------------------------------------------
// ETC1 texel decode package
// Shared types, the intensity modifier table and the channel helpers used by
// the texel decode datapath and the top level.
// ----------------------------------------------------------------------------
package etc1_pkg;

  // One decoded texel, eight bits per channel.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgba_t;

  localparam int unsigned TableIdxW = 3;
  localparam int unsigned ModW      = 8;

  // Intensity modifier magnitude, selected by table index and the
  // texel's modifier-select bit.
  function automatic logic [ModW-1:0] mod_value(input logic [TableIdxW-1:0] tbl,
                                                input logic                 sel);
    logic [ModW-1:0] lo;
    logic [ModW-1:0] hi;
    begin
      lo = 8'd2;
      hi = 8'd8;
      unique case (tbl)
        3'd0: begin lo = 8'd2;  hi = 8'd8;   end
        3'd1: begin lo = 8'd5;  hi = 8'd17;  end
        3'd2: begin lo = 8'd9;  hi = 8'd29;  end
        3'd3: begin lo = 8'd13; hi = 8'd42;  end
        3'd4: begin lo = 8'd18; hi = 8'd60;  end
        3'd5: begin lo = 8'd24; hi = 8'd80;  end
        3'd6: begin lo = 8'd33; hi = 8'd106; end
        default: begin lo = 8'd47; hi = 8'd183; end
      endcase
      mod_value = sel ? hi : lo;
    end
  endfunction

  // Replicate a 4-bit value into 8 bits.
  function automatic logic [7:0] expand4(input logic [3:0] n);
    expand4 = {n, n};
  endfunction

  // Replicate a 5-bit value into 8 bits.
  function automatic logic [7:0] expand5(input logic [4:0] n);
    expand5 = {n, n[4:2]};
  endfunction

  // Add or subtract the modifier and saturate to 0..255.
  function automatic logic [7:0] clamp_add(input logic [7:0]      c,
                                           input logic [ModW-1:0] m,
                                           input logic            neg);
    logic signed [9:0] s;
    begin
      if (neg) begin
        s = $signed({2'b00, c}) - $signed({2'b00, m});
      end else begin
        s = $signed({2'b00, c}) + $signed({2'b00, m});
      end
      if (s < 0) begin
        clamp_add = 8'd0;
      end else if (s > 10'sd255) begin
        clamp_add = 8'hFF;
      end else begin
        clamp_add = s[7:0];
      end
    end
  endfunction

endpackage

>>> hdl/etc1_texel_calc.sv
// ----------------------------------------------------------------------------
// ETC1 texel calculation
// Combinational decode of one texel: sub-block choice, base color expansion
// in individual or differential mode, modifier add with clamp, and alpha.
// ----------------------------------------------------------------------------
module etc1_texel_calc (
  input  logic [1:0]     texel_col_i,
  input  logic [1:0]     texel_row_i,
  input  logic [63:0]    colour_block_i,
  input  logic [63:0]    alpha_block_i,
  input  logic           has_alpha_i,
  output etc1_pkg::rgba_t texel_o
);
  import etc1_pkg::*;

  logic [3:0]           tix;
  logic                 flip;
  logic                 diff;
  logic                 second;
  logic [4:0]           base_r, base_g, base_b;
  logic [4:0]           sum_r, sum_g, sum_b;
  logic [7:0]           col_r, col_g, col_b;
  logic [TableIdxW-1:0] tbl;
  logic [ModW-1:0]      mod_mag;
  logic                 neg;
  logic [3:0]           alpha_nib;

  // Texel index is column-major within the block.
  assign tix    = {texel_col_i, texel_row_i};
  assign flip   = colour_block_i[32];
  assign diff   = colour_block_i[33];
  assign second = flip ? texel_row_i[1] : texel_col_i[1];

  // Differential mode: 5-bit base plus sign-extended 3-bit delta, wrapping.
  assign base_r = colour_block_i[63:59];
  assign base_g = colour_block_i[55:51];
  assign base_b = colour_block_i[47:43];
  assign sum_r  = base_r + {{2{colour_block_i[58]}}, colour_block_i[58:56]};
  assign sum_g  = base_g + {{2{colour_block_i[50]}}, colour_block_i[50:48]};
  assign sum_b  = base_b + {{2{colour_block_i[42]}}, colour_block_i[42:40]};

  // Base color of the texel's sub-block.
  always_comb begin
    if (diff) begin
      col_r = expand5(second ? sum_r : base_r);
      col_g = expand5(second ? sum_g : base_g);
      col_b = expand5(second ? sum_b : base_b);
    end else begin
      col_r = expand4(second ? colour_block_i[59:56] : colour_block_i[63:60]);
      col_g = expand4(second ? colour_block_i[51:48] : colour_block_i[55:52]);
      col_b = expand4(second ? colour_block_i[43:40] : colour_block_i[47:44]);
    end
  end

  // Modifier selection and sign; the negate bits start at bit 16.
  assign tbl     = second ? colour_block_i[36:34] : colour_block_i[39:37];
  assign mod_mag = mod_value(tbl, colour_block_i[{2'b00, tix}]);
  assign neg     = colour_block_i[{2'b01, tix}];

  assign alpha_nib = alpha_block_i[{tix, 2'b00} +: 4];

  // Final channels.
  always_comb begin
    texel_o.red   = clamp_add(col_r, mod_mag, neg);
    texel_o.green = clamp_add(col_g, mod_mag, neg);
    texel_o.blue  = clamp_add(col_b, mod_mag, neg);
    texel_o.alpha = has_alpha_i ? expand4(alpha_nib) : 8'hFF;
  end

endmodule

>>> hdl/etc1_texel_decode_unit.sv
// ----------------------------------------------------------------------------
// ETC1 texel decode unit
// Two-stage decoder of single ETC1 / ETC1A4 texels into RGBA8.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid_i / in_ready_o) carries the texel column and
//   row within its 4x4 block, the 64-bit color word and the 64-bit alpha
//   word. Each transaction produces exactly one transaction on the output
//   channel (out_valid_o / out_ready_i) with red, green, blue and alpha.
//   An accepted texel goes from the input register through the decode
//   pass into the result register, which holds it for the output
//   handshake. While the receiver keeps out_ready_i high, throughput is
//   one texel per cycle, set by the single decode pass between the two
//   registers. When the receiver stalls, the result register holds its
//   texel and the input register holds the next one, so two transactions
//   can be in flight; in_ready_o drops only when both are occupied.
//   The has_alpha mode is written through the cfg channel (always ready)
//   and should change only while no transaction is in flight.
//   Reset empties both stages and clears has_alpha to opaque mode.
// ----------------------------------------------------------------------------
module etc1_texel_decode_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i,
  // Input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  texel_col_i,
  input  logic [1:0]  texel_row_i,
  input  logic [63:0] colour_block_i,
  input  logic [63:0] alpha_block_i,
  // Output channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic [7:0]  alpha_out_o
);
  import etc1_pkg::*;

  logic        has_alpha_q;
  logic        s0_valid_q, s0_valid_d;
  logic [1:0]  col_q, row_q;
  logic [63:0] cw_q, aw_q;
  logic        out_valid_q, out_valid_d;
  rgba_t       texel_d, texel_q;
  logic        in_fire;
  logic        s1_ready;
  logic        s0_advance;

  // Configuration register.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      has_alpha_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      has_alpha_q <= cfg_data_i;
    end
  end

  // Pipeline flow control.
  assign s1_ready    = !out_valid_q || out_ready_i;
  assign in_ready_o  = !s0_valid_q || s1_ready;
  assign in_fire     = in_valid_i && in_ready_o;
  assign s0_advance  = s0_valid_q && s1_ready;
  assign s0_valid_d  = in_fire ? 1'b1 : (s0_advance ? 1'b0 : s0_valid_q);
  assign out_valid_d = s1_ready ? s0_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s0_valid_q  <= s0_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Input register.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      col_q <= texel_col_i;
      row_q <= texel_row_i;
      cw_q  <= colour_block_i;
      aw_q  <= alpha_block_i;
    end
  end

  // Decode pass.
  etc1_texel_calc u_calc (
    .texel_col_i    (col_q),
    .texel_row_i    (row_q),
    .colour_block_i (cw_q),
    .alpha_block_i  (aw_q),
    .has_alpha_i    (has_alpha_q),
    .texel_o        (texel_d)
  );

  // Result register.
  always_ff @(posedge clk_i) begin
    if (s0_advance) begin
      texel_q <= texel_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_o       = texel_q.red;
  assign green_o     = texel_q.green;
  assign blue_o      = texel_q.blue;
  assign alpha_out_o = texel_q.alpha;

  // An accepted transaction always lands in the input register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> s0_valid_q)
    else $error("accepted transaction did not reach the input register");

  // A stalled input stage keeps its transaction intact.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s0_valid_q && !s1_ready) |=> (s0_valid_q && $stable(cw_q) && $stable(aw_q)
                                   && $stable(col_q) && $stable(row_q)))
    else $error("input stage lost or changed a stalled transaction");

  // A transaction leaving the input stage shows up as a valid result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s0_advance |=> out_valid_q)
    else $error("decoded texel did not reach the result register");

  // The input stage never drains while the result register is blocked.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i && s0_valid_q) |=> (out_valid_q && s0_valid_q))
    else $error("pipeline dropped a transaction under stall");

endmodule

>>> tb/sv/etc1_texel_decode_unit_tb.sv
// ----------------------------------------------------------------------------
// ETC1 texel decode unit testbench
// Sends single texels of random and hand-built ETC1 blocks through the decode
// unit in opaque and ETC1A4 modes, with random idle cycles on both channels
// and one long output stall. An independent decoder predicts every texel,
// and a scoreboard checks each output transaction channel by channel in
// order.
// ----------------------------------------------------------------------------
module etc1_texel_decode_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import etc1_pkg::rgba_t;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldAt     = 150;
  localparam int unsigned HoldLen    = 80;
  localparam int unsigned RandItems  = 270;

  // Intensity modifier magnitudes, indexed by table and modifier-select bit.
  localparam int unsigned ModMagnitude [8][2] = '{
    '{2, 8}, '{5, 17}, '{9, 29}, '{13, 42},
    '{18, 60}, '{24, 80}, '{33, 106}, '{47, 183}
  };

  // Decodes texels on its own and checks the unit's output against them.
  class texel_scoreboard;
    rgba_t       expected_q[$];
    bit          alpha_mode;
    int unsigned checked;
    int unsigned mismatches;

    function automatic rgba_t predict_texel(bit [1:0] col, bit [1:0] row,
                                            bit [63:0] cw, bit [63:0] aw);
      bit [3:0] tix;
      bit       upper;
      bit [2:0] tbl;
      bit [4:0] base5;
      bit [3:0] nib;
      int       delta;
      int       hi;
      int       mag;
      int       level [3];
      rgba_t    res;
      tix   = {col, row};
      upper = cw[32] ? row[1] : col[1];
      tbl   = upper ? cw[36:34] : cw[39:37];
      mag   = int'(ModMagnitude[tbl][cw[tix]]);
      if (cw[16 + tix]) begin
        mag = -mag;
      end
      // Red, green and blue fields sit eight bits apart, red on top.
      for (int c = 0; c < 3; c++) begin
        hi = 59 - 8 * c;
        if (cw[33]) begin
          base5 = cw[hi +: 5];
          if (upper) begin
            delta = $signed(cw[hi - 3 +: 3]);
            base5 = 5'(int'(base5) + delta);
          end
          level[c] = {base5, base5[4:2]};
        end else begin
          nib = upper ? cw[hi - 3 +: 4] : cw[hi + 1 +: 4];
          level[c] = {nib, nib};
        end
        level[c] = level[c] + mag;
        if (level[c] < 0) begin
          level[c] = 0;
        end else if (level[c] > 255) begin
          level[c] = 255;
        end
      end
      nib       = aw[4 * tix +: 4];
      res.red   = 8'(level[0]);
      res.green = 8'(level[1]);
      res.blue  = 8'(level[2]);
      res.alpha = alpha_mode ? {nib, nib} : 8'hFF;
      return res;
    endfunction

    function void note_texel(bit [1:0] col, bit [1:0] row, bit [63:0] cw,
                             bit [63:0] aw);
      expected_q.push_back(predict_texel(col, row, cw, aw));
    endfunction

    function void check_channel(string name, bit [7:0] want, bit [7:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(rgba_t got);
      rgba_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected texel, expected none, actual %h", $time, got);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      checked++;
      check_channel("red", want.red, got.red);
      check_channel("green", want.green, got.green);
      check_channel("blue", want.blue, got.blue);
      check_channel("alpha", want.alpha, got.alpha);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic        cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  texel_col_i;
  logic [1:0]  texel_row_i;
  logic [63:0] colour_block_i;
  logic [63:0] alpha_block_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [7:0]  red_o;
  logic [7:0]  green_o;
  logic [7:0]  blue_o;
  logic [7:0]  alpha_out_o;

  texel_scoreboard book = new();
  int unsigned     max_gap = 10;
  int unsigned     cycles;

  etc1_texel_decode_unit i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .texel_col_i    (texel_col_i),
    .texel_row_i    (texel_row_i),
    .colour_block_i (colour_block_i),
    .alpha_block_i  (alpha_block_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .red_o          (red_o),
    .green_o        (green_o),
    .blue_o         (blue_o),
    .alpha_out_o    (alpha_out_o)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog on the total run length.
  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("FAIL etc1_texel_decode_unit");
    $finish;
  end

  // Offers one texel after a random gap and returns at its acceptance edge.
  // Valid is only lowered when a gap follows, so it never toggles in one step.
  task automatic send_texel(bit [1:0] col, bit [1:0] row, bit [63:0] cw,
                            bit [63:0] aw);
    int unsigned gap;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    texel_col_i    <= col;
    texel_row_i    <= row;
    colour_block_i <= cw;
    alpha_block_i  <= aw;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    book.note_texel(col, row, cw, aw);
  endtask

  // Stops offering texels and waits until every expected texel has come out.
  task automatic drain_texels();
    in_valid_i <= 1'b0;
    while (book.expected_q.size() != 0) @(posedge clk_i);
  endtask

  // Writes the alpha mode register through the configuration channel.
  task automatic write_alpha_mode(bit mode);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= mode;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    book.alpha_mode = mode;
  endtask

  // Hand-built blocks: extremes, saturation, delta wrap and both flip settings.
  task automatic run_corners();
    bit [1:0]  col;
    bit [1:0]  row;
    bit [63:0] cw;
    bit [63:0] aw;
    for (int k = 0; k < 8; k++) begin
      aw = {$urandom, $urandom};
      case (k)
        0: begin
          col = 2'd0; row = 2'd0; cw = '0; aw = '0;
        end
        1: begin
          col = 2'd3; row = 2'd3; cw = '1; aw = '1;
        end
        // Full-scale individual base plus the largest modifier saturates high.
        2: begin
          col = 2'd1; row = 2'd2;
          cw  = {24'hF0F0F0, 3'd7, 3'd0, 1'b0, 1'b0, 16'h0000, 16'h0040};
        end
        // Zero base minus the largest modifier saturates low.
        3: begin
          col = 2'd1; row = 2'd2;
          cw  = {24'h000000, 3'd7, 3'd0, 1'b0, 1'b0, 16'h0040, 16'h0040};
        end
        // Base 31 plus delta 3 wraps up past the 5-bit range; blue wraps down.
        4: begin
          col = 2'd2; row = 2'd1;
          cw  = {24'hFBFB04, 3'd0, 3'd0, 1'b1, 1'b0, 16'h0000, 16'h0200};
        end
        // Base 0 plus delta -4 wraps below zero on every channel.
        5: begin
          col = 2'd3; row = 2'd3;
          cw  = {24'h040404, 3'd2, 3'd5, 1'b1, 1'b0, 16'h8000, 16'h0000};
        end
        // Flipped block, differential, texel in the top sub-block.
        6: begin
          col = 2'd3; row = 2'd0;
          cw  = {24'h8A5F21, 3'd4, 3'd1, 1'b1, 1'b1, 16'h1000, 16'h1000};
        end
        // Flipped block, individual, texel in the bottom sub-block.
        default: begin
          col = 2'd0; row = 2'd3;
          cw  = {24'h3C5A96, 3'd6, 3'd3, 1'b0, 1'b1, 16'h0008, 16'h0000};
        end
      endcase
      send_texel(col, row, cw, aw);
    end
  endtask

  // Output receiver: random ready gaps, plus one long hold so the unit fills.
  initial begin
    int unsigned wait_cycles;
    bit          hold_done;
    hold_done   = 1'b0;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (!hold_done && book.checked >= HoldAt) begin
        hold_done   = 1'b1;
        wait_cycles = HoldLen;
      end else begin
        wait_cycles = $urandom_range(0, max_gap);
      end
      if (wait_cycles > 0) begin
        out_ready_i <= 1'b0;
        repeat (wait_cycles) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  // Checks every output transaction against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      book.check_result({red_o, green_o, blue_o, alpha_out_o});
    end
  end

  // Reset, directed blocks, then random phases in both alpha modes.
  initial begin
    bit [63:0] cw;
    bit [63:0] aw;
    in_valid_i     <= 1'b0;
    texel_col_i    <= '0;
    texel_row_i    <= '0;
    colour_block_i <= '0;
    alpha_block_i  <= '0;
    cfg_valid_i    <= 1'b0;
    cfg_data_i     <= 1'b0;
    rst_ni         <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_alpha_mode(1'b0);
    run_corners();
    // Every modifier table, written to both sub-block table fields.
    for (int t = 0; t < 8; t++) begin
      cw = {$urandom, $urandom};
      cw[39:34] = {3'(t), 3'(t)};
      send_texel(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), cw,
                 {$urandom, $urandom});
    end
    drain_texels();

    write_alpha_mode(1'b1);
    run_corners();
    drain_texels();

    // Random blocks; the third phase runs without idle cycles.
    for (int p = 0; p < 4; p++) begin
      max_gap = (p == 2) ? 0 : 10;
      write_alpha_mode(p % 2 == 0);
      repeat (RandItems) begin
        cw = {$urandom, $urandom};
        aw = {$urandom, $urandom};
        case ($urandom_range(0, 7))
          0: cw[63:40] = '0;
          1: cw[63:40] = '1;
          default: ;
        endcase
        send_texel(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), cw, aw);
      end
      drain_texels();
    end

    // Leave room for any stray output before the verdict.
    repeat (6) @(posedge clk_i);
    if (book.mismatches == 0 && book.expected_q.size() == 0) begin
      $display("PASS etc1_texel_decode_unit");
    end else begin
      $display("FAIL etc1_texel_decode_unit");
    end
    $finish;
  end

endmodule
